// File: rtl/fpa_pkg.sv
package fpa_pkg;

   // operation codes
   localparam logic [3:0] FUNC_ADD      = 4'd0;
   localparam logic [3:0] FUNC_SUB      = 4'd1;
   localparam logic [3:0] FUNC_MUL      = 4'd2;
   localparam logic [3:0] FUNC_DIV      = 4'd3;
   localparam logic [3:0] FUNC_MIN      = 4'd4;
   localparam logic [3:0] FUNC_MAX      = 4'd5;
   localparam logic [3:0] FUNC_INC      = 4'd6;
   localparam logic [3:0] FUNC_DEC      = 4'd7;
   localparam logic [3:0] FUNC_TO_INT   = 4'd8;
   localparam logic [3:0] FUNC_FROM_INT = 4'd9;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               a_less;
      logic               a_equal;
      logic               div_by_zero;
   } rsp_type;

   // control and finished result that travel beside the divider
   typedef struct packed {
      logic        valid;
      logic        is_div;
      logic        dz;
      logic        neg;
      logic        a_less;
      logic        a_equal;
      logic [31:0] result;
   } side_type;

endpackage

// File: rtl/fpa_if.sv
interface fpa_req_if import fpa_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/fpa_front.sv
module fpa_front import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  req_type     in_req,
   output side_type    side_out,
   output logic [31:0] amag_out,
   output logic [31:0] bmag_out
);

   localparam logic [63:0] BIAS = 64'((64'd1 << FRAC_BITS) - 64'd1);

   // stage 1: capture operands
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff, s1_req_in;

   // stage 2: product and plain results
   logic               s2_valid_ff, s2_valid_in;
   logic [3:0]         s2_func_ff, s2_func_in;
   logic signed [31:0] s2_a_ff, s2_a_in, s2_b_ff, s2_b_in;
   logic signed [63:0] s2_prod_ff, s2_prod_in;
   logic [31:0]        s2_res_ff, s2_res_in;
   logic               s2_less_ff, s2_less_in, s2_equal_ff, s2_equal_in;

   // stage 3: product scaling, magnitudes for the divider
   side_type    s3_side_ff, s3_side_in;
   logic [31:0] s3_amag_ff, s3_amag_in, s3_bmag_ff, s3_bmag_in;

   logic signed [63:0] ta_sum;
   logic signed [63:0] tp_sum;

   assign s1_valid_in = in_valid;
   assign s1_req_in   = in_req;

   // plain operations from stage 1
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_func_in  = s1_req_ff.func;
      s2_a_in     = s1_req_ff.operand_a;
      s2_b_in     = s1_req_ff.operand_b;
      s2_prod_in  = 64'(s1_req_ff.operand_a) * 64'(s1_req_ff.operand_b);
      s2_less_in  = s1_req_ff.operand_a < s1_req_ff.operand_b;
      s2_equal_in = s1_req_ff.operand_a == s1_req_ff.operand_b;
      ta_sum = 64'(s1_req_ff.operand_a) + (s1_req_ff.operand_a[31] ? BIAS : 64'd0);
      case (s1_req_ff.func)
         FUNC_ADD:      s2_res_in = s1_req_ff.operand_a + s1_req_ff.operand_b;
         FUNC_SUB:      s2_res_in = s1_req_ff.operand_a - s1_req_ff.operand_b;
         FUNC_MIN:      s2_res_in = s2_less_in ? s1_req_ff.operand_a : s1_req_ff.operand_b;
         FUNC_MAX:      s2_res_in = s2_less_in ? s1_req_ff.operand_b : s1_req_ff.operand_a;
         FUNC_INC:      s2_res_in = s1_req_ff.operand_a + 32'sd1;
         FUNC_DEC:      s2_res_in = s1_req_ff.operand_a - 32'sd1;
         FUNC_TO_INT:   s2_res_in = ta_sum[FRAC_BITS+31:FRAC_BITS];
         FUNC_FROM_INT: s2_res_in = 32'(s1_req_ff.operand_a << FRAC_BITS);
         default:       s2_res_in = 32'd0;
      endcase
   end

   // product truncated toward zero, divider setup
   always_comb begin
      tp_sum = s2_prod_ff + (s2_prod_ff[63] ? BIAS : 64'd0);
      s3_side_in.valid   = s2_valid_ff;
      s3_side_in.is_div  = (s2_func_ff == FUNC_DIV) && (s2_b_ff != 32'sd0);
      s3_side_in.dz      = (s2_func_ff == FUNC_DIV) && (s2_b_ff == 32'sd0);
      s3_side_in.neg     = s2_a_ff[31] ^ s2_b_ff[31];
      s3_side_in.a_less  = s2_less_ff;
      s3_side_in.a_equal = s2_equal_ff;
      s3_side_in.result  = (s2_func_ff == FUNC_MUL) ? tp_sum[FRAC_BITS+31:FRAC_BITS]
                                                    : s2_res_ff;
      s3_amag_in = s2_a_ff[31] ? 32'(-s2_a_ff) : 32'(s2_a_ff);
      s3_bmag_in = s2_b_ff[31] ? 32'(-s2_b_ff) : 32'(s2_b_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_side_ff  <= '0;
      end else if (enable) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_side_ff  <= s3_side_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_req_ff   <= s1_req_in;
         s2_func_ff  <= s2_func_in;
         s2_a_ff     <= s2_a_in;
         s2_b_ff     <= s2_b_in;
         s2_prod_ff  <= s2_prod_in;
         s2_res_ff   <= s2_res_in;
         s2_less_ff  <= s2_less_in;
         s2_equal_ff <= s2_equal_in;
         s3_amag_ff  <= s3_amag_in;
         s3_bmag_ff  <= s3_bmag_in;
      end
   end

   assign side_out = s3_side_ff;
   assign amag_out = s3_amag_ff;
   assign bmag_out = s3_bmag_ff;

endmodule

// File: rtl/fpa_div.sv
module fpa_div import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  side_type    side_in,
   input  logic [31:0] amag_in,
   input  logic [31:0] bmag_in,
   output side_type    side_out,
   output logic [31:0] quo_out
);

   localparam int DW = 32 + FRAC_BITS;

   side_type          side_ff [DW];
   logic [31:0]       rem_ff  [DW];
   logic [DW-1:0]     dend_ff [DW];
   logic [31:0]       quo_ff  [DW];
   logic [31:0]       dvs_ff  [DW];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < DW; k++) begin : g_stage
      side_type      side_in_k;
      logic [31:0]   rem_k, quo_k, dvs_k;
      logic [DW-1:0] dend_k;
      logic [32:0]   trial;
      logic          ge;
      logic [31:0]   rem_in;

      if (k == 0) begin : g_first
         assign side_in_k = side_in;
         assign rem_k     = 32'd0;
         assign quo_k     = 32'd0;
         assign dvs_k     = bmag_in;
         assign dend_k    = {amag_in, {FRAC_BITS{1'b0}}};
      end else begin : g_next
         assign side_in_k = side_ff[k-1];
         assign rem_k     = rem_ff[k-1];
         assign quo_k     = quo_ff[k-1];
         assign dvs_k     = dvs_ff[k-1];
         assign dend_k    = dend_ff[k-1];
      end

      assign trial  = {rem_k, dend_k[DW-1]};
      assign ge     = trial >= {1'b0, dvs_k};
      assign rem_in = ge ? 32'(trial - {1'b0, dvs_k}) : trial[31:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k] <= '0;
         end else if (enable) begin
            side_ff[k] <= side_in_k;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= {quo_k[30:0], ge};
            dvs_ff[k]  <= dvs_k;
            dend_ff[k] <= {dend_k[DW-2:0], 1'b0};
         end
      end
   end

   assign side_out = side_ff[DW-1];
   assign quo_out  = quo_ff[DW-1];

endmodule

// File: rtl/fixed_point_q24_8_alu_core.sv
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fractional bits: add, sub,
// mul and div (truncating toward zero), min, max, inc, dec and integer conversion, all
// wrapping to 32 bits, with signed compare flags on every result and a divide-by-zero
// flag (result 0). A new transfer is taken every cycle while the result register is free or
// being taken; every operation passes through the 32 + FRAC_BITS stage restoring divider.
// The whole pipeline holds while the result waits.
module fixed_point_q24_8_alu_core import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   fpa_req_if.sink    req,
   fpa_rsp_if.source  rsp
);

   logic        enable;
   side_type    front_side, div_side;
   logic [31:0] amag, bmag, quo;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // pipeline moves whenever the output is free or being taken
   assign enable    = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req.valid),
      .in_req   (req.payload),
      .side_out (front_side),
      .amag_out (amag),
      .bmag_out (bmag)
   );

   fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .side_in  (front_side),
      .amag_in  (amag),
      .bmag_in  (bmag),
      .side_out (div_side),
      .quo_out  (quo)
   );

   // quotient sign and final select
   always_comb begin
      rsp_valid_in            = div_side.valid;
      rsp_data_in.a_less      = div_side.a_less;
      rsp_data_in.a_equal     = div_side.a_equal;
      rsp_data_in.div_by_zero = div_side.dz;
      if (div_side.is_div) begin
         rsp_data_in.result = div_side.neg ? -quo : quo;
      end else begin
         rsp_data_in.result = div_side.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule

// File: sim/fpa_tb_if.sv
`timescale 1ns / 1ps
// the block's own interfaces live in rtl/fpa_if.sv; nothing extra needed here
package fpa_tb_pkg;
   import fpa_pkg::*;
   localparam int FRAC = 8;
endpackage

// File: sim/tb_fixed_point_q24_8_alu_core.sv
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu_core;
   import fpa_pkg::*;
   import fpa_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count = 0;
   int   sent_count = 0;
   int   recv_count = 0;
   int   hold_cycles = 0;
   rsp_type alu_expected[$];

   fpa_req_if req_if ();
   fpa_rsp_if rsp_if ();

   fixed_point_q24_8_alu_core #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   // clock generation
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted result of one operation
   function automatic rsp_type alu_predict(req_type item);
      rsp_type r;
      longint sa, sb;
      sa = longint'(item.operand_a);
      sb = longint'(item.operand_b);
      r.result = '0;
      r.div_by_zero = 1'b0;
      r.a_less = sa < sb;
      r.a_equal = sa == sb;
      case (item.func)
         FUNC_ADD: r.result = item.operand_a + item.operand_b;
         FUNC_SUB: r.result = item.operand_a - item.operand_b;
         FUNC_MUL: r.result = 32'((sa * sb) / (longint'(1) << FRAC));
         FUNC_DIV: begin
            if (sb == 0) r.div_by_zero = 1'b1;
            else r.result = 32'((sa * (longint'(1) << FRAC)) / sb);
         end
         FUNC_MIN: r.result = (sa < sb) ? item.operand_a : item.operand_b;
         FUNC_MAX: r.result = (sa < sb) ? item.operand_b : item.operand_a;
         FUNC_INC: r.result = item.operand_a + 32'sd1;
         FUNC_DEC: r.result = item.operand_a - 32'sd1;
         FUNC_TO_INT: r.result = 32'(sa / (longint'(1) << FRAC));
         FUNC_FROM_INT: r.result = item.operand_a << FRAC;
         default: r.result = '0;
      endcase
      return r;
   endfunction

   // send one operation, with a random gap first; valid stays high between
   // back to back transfers
   task automatic send_op(input logic [3:0] f, input logic [31:0] a, input logic [31:0] b,
                          input bit no_gap = 0);
      int gap;
      req_type item;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      item.func = f;
      item.operand_a = a;
      item.operand_b = b;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      alu_expected.push_back(alu_predict(item));
      sent_count++;
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 | $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 2048) - 1024;
         3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // extremes, every operation, divide by zero, unused codes
   task automatic test_directed();
      logic [31:0] edges[5];
      edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_0100};
      for (int f = 0; f < 10; f++)
         send_op(4'(f), edges[f % 5], edges[(f + 2) % 5]);
      send_op(FUNC_DIV, 32'h0000_0300, 32'h0);
      send_op(FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000);
      send_op(FUNC_MIN, 32'h1234, 32'h1234);
      send_op(FUNC_MAX, 32'hFFFF_FF00, 32'h100);
      send_op(FUNC_TO_INT, 32'hFFFF_FF01, 32'h0);
      send_op(4'd10, 32'h5, 32'h5);
      send_op(4'd15, 32'hFFFF_FFFF, 32'h0);
      send_op(FUNC_INC, 32'h7FFF_FFFF, 32'h1);
      send_op(FUNC_DEC, 32'h8000_0000, 32'h1);
   endtask

   // random operations over all codes
   task automatic test_random(input int count);
      logic [31:0] a, b;
      logic [3:0] f;
      for (int i = 0; i < count; i++) begin
         f = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
         a = rand_operand();
         b = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? a : 32'h0)
                                         : rand_operand();
         send_op(f, a, b);
      end
   endtask

   // receiver stalls long while sender streams back to back
   task automatic test_backpressure();
      hold_cycles = 150;
      for (int i = 0; i < 120; i++)
         send_op(4'($urandom_range(0, 9)), rand_operand(), rand_operand(), 1);
   endtask

   // result ready: long hold when requested, else random stalls
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (stall == 0) rsp_if.ready <= 1'b1;
            else begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // compare each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (alu_expected.size() == 0) begin
            $error("result with no operation outstanding: %h", got);
            fail_count++;
         end else begin
            want = alu_expected.pop_front();
            recv_count++;
            if (got.result !== want.result) begin
               $error("result: expected %h actual %h", want.result, got.result);
               fail_count++;
            end
            if (got.a_less !== want.a_less) begin
               $error("a_less: expected %b actual %b", want.a_less, got.a_less);
               fail_count++;
            end
            if (got.a_equal !== want.a_equal) begin
               $error("a_equal: expected %b actual %b", want.a_equal, got.a_equal);
               fail_count++;
            end
            if (got.div_by_zero !== want.div_by_zero) begin
               $error("div_by_zero: expected %b actual %b", want.div_by_zero, got.div_by_zero);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #2000000;
      $display("** fixed_point_q24_8_alu_core: FAILED **");
      $finish;
   end

   // test sequence
   initial begin
      int wait_cycles;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(600);
      req_if.valid <= 1'b0;
      wait_cycles = 0;
      while (alu_expected.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      $display("sent %0d operations (directed, random, long output stall), checked %0d results",
               sent_count, recv_count);
      if (fail_count == 0 && alu_expected.size() == 0)
         $display("** fixed_point_q24_8_alu_core: PASSED **");
      else
         $display("** fixed_point_q24_8_alu_core: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_front.sv
rtl/fpa_div.sv
rtl/fixed_point_q24_8_alu_core.sv
sim/fpa_tb_if.sv
sim/tb_fixed_point_q24_8_alu_core.sv
